@@ hdl/cbm_pkg.sv @@
`timescale 1ns / 1ps

package cbm_pkg;

    // request kinds
    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_PRG   = 2'd1;
    localparam logic [1:0] REQ_CHR   = 2'd2;

    // CPU write decode
    localparam logic [15:0] ADDR_BANK_SEL  = 16'h8000;
    localparam logic [15:0] ADDR_BANK_DATA = 16'h8001;
    localparam logic [15:0] ADDR_MIRROR    = 16'hC000;

    // configuration register indexes
    localparam logic CFG_PRG_SIZE = 1'b0;
    localparam logic CFG_CHR_SIZE = 1'b1;

    localparam logic [7:0] CFG_PRG_SIZE_RST = 8'd2;
    localparam logic [7:0] CFG_CHR_SIZE_RST = 8'd1;

    // bank select codes
    localparam logic [2:0] SEL_PAIR_LAST = 3'd1;
    localparam logic [2:0] SEL_PRG_FIRST = 3'd6;

    localparam logic [7:0] PAIR_MASK       = 8'hFE;
    localparam logic [8:0] CHR_BANK_OFFSET = 9'h040;

    localparam int CHR_SLOTS = 8;
    localparam int PRG_SLOTS = 2;

    // restoring remainder: one dividend bit per cycle
    localparam int DVD_W     = 9;
    localparam int DVS_W     = 11;
    localparam int CNT_W     = $clog2(DVD_W);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DVD_W - 1);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_EXEC   = 5'b00010,
        ST_DIV    = 5'b00100,
        ST_COMMIT = 5'b01000,
        ST_RESP   = 5'b10000
    } state_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic div_step;
        logic div_commit;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_last;
        logic out_free;
    } sts_t;

endpackage

@@ hdl/cbm_ctrl.sv @@
`timescale 1ns / 1ps

module cbm_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  cbm_pkg::sts_t sts,
    output cbm_pkg::cmd_t cmd
);
    import cbm_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = sts.need_div ? ST_DIV : ST_RESP;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                cmd.div_commit = 1'b1;
                state_next     = ST_RESP;
            end
            ST_RESP: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ hdl/cbm_dp.sv @@
`timescale 1ns / 1ps

module cbm_dp (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_wr_en,
    input  logic          cfg_index,
    input  logic [7:0]    cfg_wdata,
    input  logic [1:0]    s_req_type,
    input  logic [15:0]   s_address,
    input  logic [7:0]    s_write_data,
    input  cbm_pkg::cmd_t cmd,
    output cbm_pkg::sts_t sts,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [21:0]   m_rom_offset,
    output logic          m_mirror_select
);
    import cbm_pkg::*;

    logic [7:0]  prg_size_reg;
    logic [7:0]  chr_size_reg;
    logic [1:0]  req_reg;
    logic [15:0] addr_reg;
    logic [7:0]  data_reg;
    logic [2:0]  bank_sel_reg;
    logic        mirror_reg;
    logic [8:0]  chr_pages_reg [CHR_SLOTS];
    logic [7:0]  prg_pages_reg [PRG_SLOTS];

    logic [DVD_W-1:0] dvd_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic        m_valid_reg;
    logic [21:0] offset_reg;
    logic        mirror_out_reg;

    logic [7:0]       prg_units;
    logic             is_bank_write;
    logic             sel_prg;
    logic             sel_pair;
    logic [DVS_W-1:0] dvs_init;
    logic [DVD_W-1:0] dvd_init;
    logic [DVS_W:0]   shifted;
    logic [DVS_W-1:0] rem_next;
    logic [1:0]       prg_slot;
    logic [8:0]       prg_page;
    logic [21:0]      prg_offset;
    logic [21:0]      chr_offset;
    logic [21:0]      rd_offset;
    logic [2:0]       chr_lo_idx;
    logic [2:0]       chr_hi_idx;
    logic [2:0]       chr_one_idx;

    // size zero counts as one 16KB unit
    assign prg_units     = (prg_size_reg == 8'd0) ? 8'd1 : prg_size_reg;
    assign is_bank_write = (req_reg == REQ_WRITE) && (addr_reg == ADDR_BANK_DATA);
    assign sel_prg       = bank_sel_reg >= SEL_PRG_FIRST;
    assign sel_pair      = bank_sel_reg <= SEL_PAIR_LAST;

    assign dvs_init = sel_prg ? {2'b00, prg_units, 1'b0} : {chr_size_reg, 3'b000};

    always_comb begin
        if (sel_prg) begin
            dvd_init = {1'b0, data_reg};
        end else if (sel_pair) begin
            dvd_init = {1'b0, data_reg & PAIR_MASK};
        end else begin
            dvd_init = {1'b0, data_reg} + CHR_BANK_OFFSET;
        end
    end

    assign shifted  = {rem_reg, dvd_reg[DVD_W-1]};
    assign rem_next = (shifted >= {1'b0, dvs_reg}) ? DVS_W'(shifted - {1'b0, dvs_reg})
                                                   : shifted[DVS_W-1:0];

    // pair base is even and the divisor is a multiple of 8, so base+1 never wraps
    assign chr_lo_idx  = {1'b0, bank_sel_reg[0], 1'b0};
    assign chr_hi_idx  = {1'b0, bank_sel_reg[0], 1'b1};
    assign chr_one_idx = bank_sel_reg + 3'd2;

    // last two program slots map to the final two 8KB pages
    assign prg_slot   = addr_reg[14:13];
    assign prg_page   = prg_slot[1] ? {prg_units - 8'd1, prg_slot[0]}
                                    : {1'b0, prg_pages_reg[prg_slot[0]]};
    assign prg_offset = {prg_page, addr_reg[12:0]};
    assign chr_offset = {3'b000, chr_pages_reg[addr_reg[12:10]], addr_reg[9:0]};

    always_comb begin
        case (req_reg)
            REQ_PRG: rd_offset = addr_reg[15] ? prg_offset : 22'd0;
            REQ_CHR: rd_offset = chr_offset;
            default: rd_offset = 22'd0;
        endcase
    end

    assign sts.need_div = is_bank_write && (sel_prg || (chr_size_reg != 8'd0));
    assign sts.div_last = cnt_reg == DIV_LAST;
    assign sts.out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prg_size_reg <= CFG_PRG_SIZE_RST;
            chr_size_reg <= CFG_CHR_SIZE_RST;
            bank_sel_reg <= 3'd0;
            mirror_reg   <= 1'b0;
            cnt_reg      <= '0;
            m_valid_reg  <= 1'b0;
            for (int i = 0; i < CHR_SLOTS; i++) begin
                chr_pages_reg[i] <= 9'(i);
            end
            for (int i = 0; i < PRG_SLOTS; i++) begin
                prg_pages_reg[i] <= 8'(i);
            end
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_PRG_SIZE: prg_size_reg <= cfg_wdata;
                    CFG_CHR_SIZE: chr_size_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (cmd.exec && req_reg == REQ_WRITE) begin
                if (addr_reg == ADDR_BANK_SEL) begin
                    bank_sel_reg <= data_reg[2:0];
                end else if (addr_reg == ADDR_MIRROR) begin
                    mirror_reg <= |data_reg;
                end
            end
            if (cmd.exec) begin
                cnt_reg <= '0;
            end else if (cmd.div_step) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.div_commit) begin
                if (sel_prg) begin
                    prg_pages_reg[bank_sel_reg[0]] <= rem_reg[7:0];
                end else if (sel_pair) begin
                    chr_pages_reg[chr_lo_idx] <= rem_reg[8:0];
                    chr_pages_reg[chr_hi_idx] <= rem_reg[8:0] | 9'd1;
                end else begin
                    chr_pages_reg[chr_one_idx] <= rem_reg[8:0];
                end
            end
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg  <= s_req_type;
            addr_reg <= s_address;
            data_reg <= s_write_data;
        end
        if (cmd.exec) begin
            dvd_reg <= dvd_init;
            dvs_reg <= dvs_init;
            rem_reg <= '0;
        end else if (cmd.div_step) begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
        if (cmd.load_out) begin
            offset_reg     <= rd_offset;
            mirror_out_reg <= mirror_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_rom_offset    = offset_reg;
    assign m_mirror_select = mirror_out_reg;

endmodule

@@ hdl/cartridge_bank_mapper.sv @@
`timescale 1ns / 1ps

// channel   dir  handshake              payload
// s_        in   s_valid / s_ready      s_req_type, s_address, s_write_data
// m_        out  m_valid / m_ready      m_rom_offset, m_mirror_select
// cfg       in   cfg_wr_en              cfg_index, cfg_wdata
//
// One word at a time; reads and plain writes pass through accept, execute and
// load result, and m_valid is registered at the load-result step. A bank data
// write (0x8001) adds the 9-step restoring remainder and a commit between
// execute and load result (a character load with no character ROM skips both).
// Reset is synchronous, active low; it restores the size registers and all banks.
// A new word is taken while the previous result still waits on m_ready; the
// controller then holds in its response state until the output register frees.

module cartridge_bank_mapper (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [15:0] s_address,
    input  logic [7:0]  s_write_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [21:0] m_rom_offset,
    output logic        m_mirror_select
);
    import cbm_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // sequencer: accept, execute, optional remainder loop, commit, respond
    cbm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // bank registers, remainder unit, address translation, output register
    cbm_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_req_type      (s_req_type),
        .s_address       (s_address),
        .s_write_data    (s_write_data),
        .cmd             (cmd),
        .sts             (sts),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_rom_offset    (m_rom_offset),
        .m_mirror_select (m_mirror_select)
    );

    // a word is executed in the cycle right after it was captured
    a_exec_after_capture: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec |-> $past(cmd.capture))
        else $error("execute without a captured word");

    // bank commit only follows the last remainder step
    a_commit_after_div: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_commit |-> $past(cmd.div_step && sts.div_last))
        else $error("bank commit before remainder finished");

    // a result never overwrites one still waiting downstream
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_valid || m_ready))
        else $error("output register overwritten");

    // input is closed for the cycle after an accept
    a_one_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second word taken while busy");

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import cbm_pkg::*;

    // request kind that the mapper treats as a no-op
    localparam logic [1:0] REQ_NONE = 2'd3;

    // stray CPU write targets that decode to nothing
    localparam logic [15:0] ADDR_STRAY_LO = 16'h7FFF;
    localparam logic [15:0] ADDR_STRAY_HI = 16'h8002;
    localparam logic [15:0] ADDR_STRAY_MR = 16'hC001;

    localparam int NUM_PHASES      = 6;
    localparam int WORDS_PER_PHASE = 152;
    localparam int DRAIN_LIMIT     = 100000;
    // longest accept-to-result path is the bank data write
    localparam int SETTLE_CYCLES   = 16;

    // Tracks the mapper's bank registers and predicts the translated offset and
    // mirroring for each accepted request word.
    class translation_board;
        typedef struct {
            logic [21:0] offset;
            logic        mirror;
        } xlat_t;

        xlat_t      pending_xlat[$];
        logic [7:0] prg_size;
        logic [7:0] chr_size;
        logic [2:0] bank_sel;
        logic [8:0] chr_page [CHR_SLOTS];
        logic [7:0] prg_page [PRG_SLOTS];
        logic       mirror;
        int         errors;
        int         checked;

        function new();
            errors  = 0;
            checked = 0;
            restore_defaults();
        endfunction

        function void restore_defaults();
            prg_size = CFG_PRG_SIZE_RST;
            chr_size = CFG_CHR_SIZE_RST;
            bank_sel = '0;
            for (int i = 0; i < CHR_SLOTS; i++) chr_page[i] = 9'(i);
            for (int i = 0; i < PRG_SLOTS; i++) prg_page[i] = 8'(i);
            mirror = 1'b0;
            pending_xlat.delete();
        endfunction

        // size zero counts as one 16KB unit
        function int prg_pages_total();
            int units;
            units = (prg_size == 8'd0) ? 1 : int'(prg_size);
            return units * 2;
        endfunction

        function void load_bank(logic [7:0] d);
            int sel;
            int nchr;
            int base;
            sel  = int'(bank_sel);
            nchr = int'(chr_size) * 8;
            if (bank_sel >= SEL_PRG_FIRST) begin
                prg_page[sel - int'(SEL_PRG_FIRST)] = 8'(int'(d) % prg_pages_total());
                return;
            end
            // no character ROM: character bank loads are dropped
            if (nchr == 0) return;
            if (bank_sel <= SEL_PAIR_LAST) begin
                base = int'(d & PAIR_MASK);
                chr_page[sel * 2]     = 9'(base % nchr);
                chr_page[sel * 2 + 1] = 9'((base + 1) % nchr);
            end else begin
                chr_page[sel + 2] = 9'((int'(d) + int'(CHR_BANK_OFFSET)) % nchr);
            end
        endfunction

        function void note_request(logic [1:0] req, logic [15:0] addr, logic [7:0] data);
            int    offset;
            int    slot;
            int    page;
            xlat_t x;
            offset = 0;
            case (req)
                REQ_WRITE: begin
                    if (addr == ADDR_BANK_SEL) bank_sel = data[2:0];
                    else if (addr == ADDR_BANK_DATA) load_bank(data);
                    else if (addr == ADDR_MIRROR) mirror = (data != 8'd0);
                end
                REQ_PRG: begin
                    if (addr >= ADDR_BANK_SEL) begin
                        slot = int'(addr[14:13]);
                        if (slot < PRG_SLOTS) page = int'(prg_page[slot]);
                        else page = prg_pages_total() - 4 + slot;
                        offset = page * 8192 + int'(addr[12:0]);
                    end
                end
                REQ_CHR: begin
                    slot   = int'(addr[12:10]);
                    offset = int'(chr_page[slot]) * 1024 + int'(addr[9:0]);
                end
                default: ;
            endcase
            x.offset = offset[21:0];
            x.mirror = mirror;
            pending_xlat.push_back(x);
        endfunction

        function int pending();
            return pending_xlat.size();
        endfunction

        task report(string msg);
            $display("[%0t] MISMATCH: %s", $time, msg);
            errors++;
        endtask

        task check_result(logic [21:0] offset, logic mir);
            xlat_t x;
            if (pending_xlat.size() == 0) begin
                report($sformatf("unexpected word offset=%06h mirror=%0b", offset, mir));
                return;
            end
            x = pending_xlat.pop_front();
            checked++;
            if (offset !== x.offset)
                report($sformatf("rom_offset got %06h expected %06h", offset, x.offset));
            if (mir !== x.mirror)
                report($sformatf("mirror_select got %0b expected %0b", mir, x.mirror));
        endtask
    endclass

    // ------------------------------------------------------------------
    // clock, reset, DUT ports (all inputs known from time zero)
    // ------------------------------------------------------------------
    logic        aclk            = 1'b0;
    logic        aresetn         = 1'b0;
    logic        cfg_wr_en       = 1'b0;
    logic        cfg_index       = CFG_PRG_SIZE;
    logic [7:0]  cfg_wdata       = '0;
    logic        s_valid         = 1'b0;
    logic        s_ready;
    logic [1:0]  s_req_type      = REQ_WRITE;
    logic [15:0] s_address       = '0;
    logic [7:0]  s_write_data    = '0;
    logic        m_valid;
    logic        m_ready         = 1'b0;
    logic [21:0] m_rom_offset;
    logic        m_mirror_select;

    translation_board board = new();

    int tx_idle_pct  = 0;     // chance per cycle that the sender holds off
    int rx_stall_pct = 0;     // chance per cycle that the receiver stalls
    int sent         = 0;     // request words accepted so far

    always #5 aclk = ~aclk;

    cartridge_bank_mapper dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_address       (s_address),
        .s_write_data    (s_write_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_rom_offset    (m_rom_offset),
        .m_mirror_select (m_mirror_select)
    );

    // ------------------------------------------------------------------
    // result side: sample the handshake as it stood before the edge, then
    // pick the next ready value. Stalls are drawn fresh every cycle.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) board.check_result(m_rom_offset, m_mirror_select);
            m_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------

    // Offer one word; holds valid and payload until accepted. Called right
    // after a rising edge, and returns right after the accepting edge, so a
    // back-to-back word keeps valid high with a single assignment per step.
    task automatic send_word(input logic [1:0] req, input logic [15:0] addr,
                             input logic [7:0] data);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_req_type   <= req;
        s_address    <= addr;
        s_write_data <= data;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_request(req, addr, data);
        sent++;
    endtask

    // bytes lean toward the extremes now and then
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // Mostly well-formed traffic: select+load pairs, mirroring, and program
    // and character translations; the rest is stray writes and the no-op kind.
    task automatic send_random_item();
        int          pick;
        logic [15:0] addr;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            send_word(REQ_WRITE, ADDR_BANK_SEL, 8'($urandom));
            send_word(REQ_WRITE, ADDR_BANK_DATA, pick_byte());
        end else if (pick < 38) begin
            send_word(REQ_WRITE, ADDR_MIRROR, ($urandom_range(0, 1) == 0) ? 8'h00 : pick_byte());
        end else if (pick < 63) begin
            // a fifth of program reads land anywhere, including below the window
            addr = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                               : 16'($urandom_range(16'h8000, 16'hFFFF));
            send_word(REQ_PRG, addr, 8'($urandom));
        end else if (pick < 88) begin
            // full 16-bit address: upper PPU bits must wrap away
            send_word(REQ_CHR, 16'($urandom), 8'($urandom));
        end else if (pick < 94) begin
            send_word(REQ_NONE, 16'($urandom), 8'($urandom));
        end else begin
            case ($urandom_range(0, 3))
                0:       addr = ADDR_STRAY_LO;
                1:       addr = ADDR_STRAY_HI;
                2:       addr = ADDR_STRAY_MR;
                default: addr = 16'($urandom);
            endcase
            send_word(REQ_WRITE, addr, pick_byte());
        end
    endtask

    // Size registers change only with the mapper idle: drain all results, let
    // the longest internal path settle, then write both registers.
    task automatic write_sizes(input logic [7:0] prg, input logic [7:0] chr);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (board.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_PRG_SIZE;
        cfg_wdata <= prg;
        @(posedge aclk);
        board.prg_size = prg;
        cfg_index <= CFG_CHR_SIZE;
        cfg_wdata <= chr;
        @(posedge aclk);
        board.chr_size = chr;
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        logic [7:0] prg_plan [NUM_PHASES];
        logic [7:0] chr_plan [NUM_PHASES];
        int         quota;
        int         pause_at;
        int         drained;
        bit         paused;

        // size settings per phase: defaults, both maximal, no character ROM,
        // program size zero, random, then mid-range
        prg_plan = '{8'd2, 8'd255, 8'd1, 8'd0, 8'd1, 8'd128};
        chr_plan = '{8'd1, 8'd255, 8'd0, 8'd3, 8'd0, 8'd32};
        prg_plan[4] = 8'($urandom_range(1, 255));
        chr_plan[4] = 8'($urandom_range(0, 255));
        paused = 1'b0;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            // idle mix: none, sender 50%, receiver 50%, both 27%
            case (phase % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 50; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 50; end
                default: begin tx_idle_pct = 27; rx_stall_pct = 27; end
            endcase
            if (phase != 0) write_sizes(prg_plan[phase], chr_plan[phase]);

            if (phase == 0) begin
                // character reads at both ends, and one that must wrap
                send_word(REQ_CHR, 16'h0000, 8'h00);
                send_word(REQ_CHR, 16'h1FFF, 8'hFF);
                send_word(REQ_CHR, 16'hFFFF, 8'h00);
                // program reads: below the window, first byte, last byte, fixed slot
                send_word(REQ_PRG, 16'h7FFF, 8'h00);
                send_word(REQ_PRG, 16'h8000, 8'hFF);
                send_word(REQ_PRG, 16'hFFFF, 8'h00);
                send_word(REQ_PRG, 16'hC000, 8'h00);
                send_word(REQ_NONE, 16'hFFFF, 8'hFF);
                send_word(REQ_WRITE, ADDR_STRAY_HI, 8'hFF);
                // mirroring: nonzero, zero, lowest nonzero
                send_word(REQ_WRITE, ADDR_MIRROR, 8'hFF);
                send_word(REQ_WRITE, ADDR_MIRROR, 8'h00);
                send_word(REQ_WRITE, ADDR_MIRROR, 8'h01);
                // loads through each kind of bank, some with upper select bits set
                send_word(REQ_WRITE, ADDR_BANK_SEL, 8'hF8);
                send_word(REQ_WRITE, ADDR_BANK_DATA, 8'hFF);
                send_word(REQ_CHR, 16'h0400, 8'h00);
                send_word(REQ_WRITE, ADDR_BANK_SEL, 8'h01);
                send_word(REQ_WRITE, ADDR_BANK_DATA, 8'h00);
                send_word(REQ_WRITE, ADDR_BANK_SEL, 8'h05);
                send_word(REQ_WRITE, ADDR_BANK_DATA, 8'hFF);
                send_word(REQ_CHR, 16'h1C00, 8'h00);
                send_word(REQ_WRITE, ADDR_BANK_SEL, 8'hFF);
                send_word(REQ_WRITE, ADDR_BANK_DATA, 8'hFF);
                send_word(REQ_PRG, 16'hA000, 8'h00);
                send_word(REQ_WRITE, ADDR_BANK_SEL, 8'h06);
                send_word(REQ_WRITE, ADDR_BANK_DATA, 8'h03);
            end else if (phase == 2) begin
                // no character ROM: the load must leave the page untouched
                send_word(REQ_WRITE, ADDR_BANK_SEL, 8'h00);
                send_word(REQ_WRITE, ADDR_BANK_DATA, 8'h33);
                send_word(REQ_CHR, 16'h0000, 8'h00);
            end else if (phase == 3) begin
                // program size zero behaves as one 16KB unit
                send_word(REQ_PRG, 16'hE000, 8'h00);
                send_word(REQ_WRITE, ADDR_BANK_SEL, 8'h07);
                send_word(REQ_WRITE, ADDR_BANK_DATA, 8'hFF);
                send_word(REQ_PRG, 16'hA000, 8'h00);
            end

            quota    = sent + WORDS_PER_PHASE;
            pause_at = sent + WORDS_PER_PHASE / 2;
            while (sent < quota) begin
                // once: hold off the sender until every result is back
                if (phase == 1 && !paused && sent >= pause_at) begin
                    paused = 1'b1;
                    s_valid <= 1'b0;
                    @(posedge aclk);
                    while (board.pending() != 0) @(posedge aclk);
                end
                send_random_item();
            end
        end

        // drain, then linger to catch any stray result
        s_valid <= 1'b0;
        drained = 0;
        while (board.pending() != 0 && drained < DRAIN_LIMIT) begin
            @(posedge aclk);
            drained++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (board.pending() != 0)
            board.report($sformatf("%0d results never arrived", board.pending()));

        $display("Ran %0d request words over %0d size settings; %0d results checked.",
                 sent, NUM_PHASES, board.checked);
        $display("Idle mixes: none, sender-only, receiver-only and both; %0d mismatches.",
                 board.errors);
        if (board.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // hard stop, far beyond the slowest legal run
    initial begin
        #5000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
